>>> rtl/core/drs_pkg.sv
`default_nettype none
package drs_pkg;

   // command codes
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_PICK = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_GRANTED = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // scheduling policies
   localparam logic [2:0] POL_FIFO  = 3'd0;
   localparam logic [2:0] POL_SSTF  = 3'd1;
   localparam logic [2:0] POL_LOOK  = 3'd2;
   localparam logic [2:0] POL_CLOOK = 3'd3;
   localparam logic [2:0] POL_FLOOK = 3'd4;

   // register indexes
   localparam logic REG_POLICY = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN1,
      S_SCAN2,
      S_REMOVE,
      S_DONE
   } state_type;

   // how a scan qualifies and ranks entries
   typedef enum logic [1:0] {
      SM_SSTF,
      SM_SWEEP,
      SM_LOWEST
   } scan_mode_type;

   // control from the sequencer to every cell
   typedef struct packed {
      logic       load;     // write the new request into the tail cell
      logic       rotate;   // every cell passes its entry one place down
      logic       remove;   // drop the rotating entry instead of passing it on
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> rtl/core/drs_cell.sv
`default_nettype none
// one queue slot: holds an entry and passes it to its lower neighbour on rotate
module drs_cell #(
   parameter int TRACK_WIDTH = 16,
   parameter int TAG_WIDTH   = 8
) (
   input  wire                       clock,
   input  wire                       reset,
   input  drs_pkg::cell_ctrl_type    ctrl,
   input  wire                       is_tail,
   input  wire                       is_last,
   input  wire  [TRACK_WIDTH-1:0]    next_track,
   input  wire  [TAG_WIDTH-1:0]      next_tag,
   input  wire                       next_set,
   input  wire                       next_valid,
   input  wire  [TRACK_WIDTH-1:0]    new_track,
   input  wire  [TAG_WIDTH-1:0]      new_tag,
   input  wire                       new_set,
   output logic [TRACK_WIDTH-1:0]    track,
   output logic [TAG_WIDTH-1:0]      tag,
   output logic                      set_bit,
   output logic                      valid
);

   logic [TRACK_WIDTH-1:0] track_ff;
   logic [TAG_WIDTH-1:0]   tag_ff;
   logic                   set_ff;
   logic                   valid_ff;

   // payload: load at the tail, or take the neighbour's entry on rotate
   always_ff @(posedge clock) begin
      if (ctrl.load && is_tail) begin
         track_ff <= new_track;
         tag_ff   <= new_tag;
         set_ff   <= new_set;
      end else if (ctrl.rotate) begin
         track_ff <= next_track;
         tag_ff   <= next_tag;
         set_ff   <= next_set;
      end
   end

   // occupancy: on a removing rotate the last occupied cell empties
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load && is_tail) begin
         valid_ff <= 1'b1;
      end else if (ctrl.rotate && ctrl.remove && is_last) begin
         valid_ff <= 1'b0;
      end else if (ctrl.rotate) begin
         valid_ff <= valid_ff & (next_valid | ~ctrl.remove);
      end
   end

   assign track   = track_ff;
   assign tag     = tag_ff;
   assign set_bit = set_ff;
   assign valid   = valid_ff;

endmodule
`default_nettype wire

>>> rtl/core/disk_request_scheduler.sv
`default_nettype none
// Disk request scheduler. Requests are held in a chain of cells in arrival
// order; cell 0 is the oldest. An add is handled in the first scan state,
// then gives its result in the done state. A pick over n queued requests
// rotates the whole chain past cell 0 once per pass (one rotation per
// queued entry) and ends with a removal pass that closes the queue around
// the chosen entry. FIFO goes straight to the removal pass. SSTF, and LOOK
// or CLOOK with a match ahead of the head, scan once. LOOK after a reversal,
// CLOOK wrapping to the lowest track, and FLOOK scan twice; FLOOK scans a
// third time when it must reverse. busy is high from the cycle after
// acceptance up to and including the result cycle. The result is shown for
// one cycle on rsp_strobe and cannot be held off. Write the policy register
// only while busy is low.
module disk_request_scheduler #(
   parameter int QUEUE_DEPTH = 32,
   parameter int TRACK_WIDTH = 16,
   parameter int TAG_WIDTH   = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire                    req_command,
   input  wire  [TRACK_WIDTH-1:0] req_track,
   input  wire  [TAG_WIDTH-1:0]   req_request_tag,
   input  wire  [TRACK_WIDTH-1:0] req_head_position,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [TAG_WIDTH-1:0]   rsp_granted_tag,
   output logic [TRACK_WIDTH-1:0] rsp_granted_track,
   output logic                   rsp_sweep_backward,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire                    paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   drs_pkg::state_type state_ff, state_in;
   drs_pkg::cell_ctrl_type ctrl;

   logic [2:0]             policy_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic                   scan_bwd_ff, scan_bwd_in;
   logic                   active_ff, active_in;
   logic                   cmd_ff;
   logic [TRACK_WIDTH-1:0] head_ff;
   logic [TRACK_WIDTH-1:0] new_track_ff;
   logic [TAG_WIDTH-1:0]   new_tag_ff;
   logic [CW-1:0]          step_ff, step_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          best_ff, best_in;
   logic [TRACK_WIDTH-1:0] best_dist_ff, best_dist_in;
   logic                   any_act_ff, any_act_in;
   logic                   use_set_ff, use_set_in;
   logic                   dir_ff, dir_in;
   drs_pkg::scan_mode_type mode_ff, mode_in;
   logic [1:0]             st_ff, st_in;
   logic [TAG_WIDTH-1:0]   otag_ff, otag_in;
   logic [TRACK_WIDTH-1:0] otrack_ff, otrack_in;

   logic [TRACK_WIDTH-1:0] c_track [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0]   c_tag   [QUEUE_DEPTH];
   logic                   c_set   [QUEUE_DEPTH];
   logic                   c_valid [QUEUE_DEPTH];

   logic                   accept;
   logic [TRACK_WIDTH-1:0] t0;
   logic [TRACK_WIDTH-1:0] scan_dist;
   logic                   qual;
   logic                   better;
   logic                   remove_now;
   logic                   rem_last;

   assign accept = start && !busy;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr == drs_pkg::REG_POLICY) ? {29'd0, policy_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= drs_pkg::POL_FIFO;
      end else if (psel && penable && pwrite && paddr == drs_pkg::REG_POLICY) begin
         policy_ff <= pwdata[2:0];
      end
   end

   // chain of cells; cell 0 is the head of the rotation
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      localparam int N = (g + 1) % QUEUE_DEPTH;
      logic is_tail, is_last;
      logic [TRACK_WIDTH-1:0] nt;
      logic [TAG_WIDTH-1:0]   ng;
      logic                   ns, nv;
      assign is_tail = (count_ff == CW'(g));
      assign is_last = (count_ff == CW'(g + 1));
      // the top occupied cell takes cell 0's entry, so the chain rotates
      assign nt = is_last ? c_track[0] : c_track[N];
      assign ng = is_last ? c_tag[0]   : c_tag[N];
      assign ns = is_last ? c_set[0]   : c_set[N];
      assign nv = is_last ? 1'b1       : c_valid[N];
      drs_cell #(.TRACK_WIDTH(TRACK_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_cell (
         .clock(clock), .reset(reset), .ctrl(ctrl),
         .is_tail(is_tail), .is_last(is_last),
         .next_track(nt), .next_tag(ng), .next_set(ns), .next_valid(nv),
         .new_track(new_track_ff), .new_tag(new_tag_ff), .new_set(~active_ff),
         .track(c_track[g]), .tag(c_tag[g]), .set_bit(c_set[g]),
         .valid(c_valid[g])
      );
   end

   // compare of the entry now at cell 0 against the best so far
   assign t0 = c_track[0];
   always_comb begin
      qual = 1'b1;
      scan_dist = '0;
      unique case (mode_ff)
         drs_pkg::SM_SSTF: begin
            scan_dist = (t0 >= head_ff) ? t0 - head_ff : head_ff - t0;
         end
         drs_pkg::SM_SWEEP: begin
            if (use_set_ff && c_set[0] != active_ff) qual = 1'b0;
            if (dir_ff) begin
               if (t0 > head_ff) qual = 1'b0;
               scan_dist = head_ff - t0;
            end else begin
               if (t0 < head_ff) qual = 1'b0;
               scan_dist = t0 - head_ff;
            end
         end
         default: begin
            scan_dist = t0;
         end
      endcase
      better = qual && (!found_ff || scan_dist < best_dist_ff);
   end

   // removal pass: the ring shrinks by one once the chosen entry has gone
   assign remove_now = (step_ff == CW'(best_ff));
   assign rem_last   = remove_now ? (step_ff == count_ff - CW'(1)) : (step_ff == count_ff);

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drs_pkg::S_IDLE:  if (accept) state_in = drs_pkg::S_SCAN1;
         drs_pkg::S_SCAN1: begin
            if (cmd_ff == drs_pkg::CMD_ADD || count_ff == '0)
               state_in = drs_pkg::S_DONE;
            else if (policy_ff == drs_pkg::POL_FIFO || policy_ff > drs_pkg::POL_FLOOK)
               state_in = drs_pkg::S_REMOVE;
            else if (step_ff == count_ff - CW'(1)) begin
               if (policy_ff == drs_pkg::POL_SSTF ||
                   (policy_ff != drs_pkg::POL_FLOOK && (found_ff || better)))
                  state_in = drs_pkg::S_REMOVE;
               else
                  state_in = drs_pkg::S_SCAN2;
            end
         end
         drs_pkg::S_SCAN2: begin
            if (step_ff == count_ff - CW'(1) && (found_ff || better))
               state_in = drs_pkg::S_REMOVE;
         end
         drs_pkg::S_REMOVE: if (rem_last) state_in = drs_pkg::S_DONE;
         default:          state_in = drs_pkg::S_IDLE;
      endcase
   end

   // sequencer: datapath and outputs
   always_comb begin
      ctrl         = '0;
      count_in     = count_ff;
      scan_bwd_in  = scan_bwd_ff;
      active_in    = active_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      any_act_in   = any_act_ff;
      use_set_in   = use_set_ff;
      dir_in       = dir_ff;
      mode_in      = mode_ff;
      st_in        = st_ff;
      otag_in      = otag_ff;
      otrack_in    = otrack_ff;
      unique case (state_ff)
         drs_pkg::S_IDLE: begin
            step_in  = '0;
            found_in = 1'b0;
            best_in  = '0;
            any_act_in = 1'b0;
            use_set_in = (policy_ff == drs_pkg::POL_FLOOK);
            dir_in   = (policy_ff == drs_pkg::POL_CLOOK) ? 1'b0 : scan_bwd_ff;
            mode_in  = (policy_ff == drs_pkg::POL_SSTF) ? drs_pkg::SM_SSTF
                                                        : drs_pkg::SM_SWEEP;
         end
         drs_pkg::S_SCAN1: begin
            otag_in   = '0;
            otrack_in = '0;
            if (cmd_ff == drs_pkg::CMD_ADD) begin
               if (count_ff == CW'(QUEUE_DEPTH)) begin
                  st_in = drs_pkg::ST_FULL;
               end else begin
                  ctrl.load = 1'b1;
                  count_in  = count_ff + CW'(1);
                  st_in     = drs_pkg::ST_ADDED;
               end
            end else if (count_ff == '0) begin
               st_in = drs_pkg::ST_EMPTY;
            end else if (policy_ff == drs_pkg::POL_FIFO || policy_ff > drs_pkg::POL_FLOOK) begin
               best_in = '0;
               step_in = '0;
            end else begin
               // first pass; FLOOK notes whether the active set has entries
               ctrl.rotate = 1'b1;
               if (c_set[0] == active_ff) any_act_in = 1'b1;
               if (better && policy_ff != drs_pkg::POL_FLOOK) begin
                  found_in = 1'b1;
                  best_in = IW'(step_ff);
                  best_dist_in = scan_dist;
               end
               if (step_ff == count_ff - CW'(1)) begin
                  step_in  = '0;
                  found_in = 1'b0;
                  if (policy_ff == drs_pkg::POL_SSTF) begin
                     // answer known; go straight to removal
                     found_in = 1'b1;
                     if (!better && found_ff) best_in = best_ff;
                     mode_in = drs_pkg::SM_SSTF;
                  end else if (policy_ff == drs_pkg::POL_FLOOK) begin
                     if (!(any_act_ff || c_set[0] == active_ff)) active_in = ~active_ff;
                  end else if (found_ff || better) begin
                     found_in = 1'b1;
                  end else if (policy_ff == drs_pkg::POL_LOOK) begin
                     scan_bwd_in = ~scan_bwd_ff;
                     dir_in = ~dir_ff;
                  end else begin
                     mode_in = drs_pkg::SM_LOWEST;
                  end
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end
         drs_pkg::S_SCAN2: begin
            // second pass: FLOOK scan, retry after reversal, or lowest track
            ctrl.rotate = 1'b1;
            if (better) begin
               found_in = 1'b1;
               best_in = IW'(step_ff);
               best_dist_in = scan_dist;
            end
            if (step_ff == count_ff - CW'(1)) begin
               step_in = '0;
               if (!found_ff && !better) begin
                  // flook: nothing ahead, reverse and scan again
                  scan_bwd_in = ~scan_bwd_ff;
                  dir_in = ~dir_ff;
                  found_in = 1'b0;
               end
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         drs_pkg::S_REMOVE: begin
            // rotate once more, dropping the chosen entry on its way past
            ctrl.rotate = 1'b1;
            ctrl.remove = remove_now;
            if (remove_now) begin
               otag_in   = c_tag[0];
               otrack_in = c_track[0];
               count_in  = count_ff - CW'(1);
            end
            if (rem_last) begin
               st_in    = drs_pkg::ST_GRANTED;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= drs_pkg::S_IDLE;
         count_ff    <= '0;
         scan_bwd_ff <= 1'b0;
         active_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_bwd_ff <= scan_bwd_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_command;
         head_ff      <= req_head_position;
         new_track_ff <= req_track;
         new_tag_ff   <= req_request_tag;
      end
      step_ff      <= step_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      any_act_ff   <= any_act_in;
      use_set_ff   <= use_set_in;
      dir_ff       <= dir_in;
      mode_ff      <= mode_in;
      st_ff        <= st_in;
      otag_ff      <= otag_in;
      otrack_ff    <= otrack_in;
   end

   // result
   assign busy               = (state_ff != drs_pkg::S_IDLE);
   assign rsp_strobe         = (state_ff == drs_pkg::S_DONE);
   assign rsp_status         = st_ff;
   assign rsp_granted_tag    = otag_ff;
   assign rsp_granted_track  = otrack_ff;
   assign rsp_sweep_backward = scan_bwd_ff;

endmodule
`default_nettype wire

>>> rtl/core/drs_checker.sv
`default_nettype none
// port-level checks on the scheduler
module drs_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_strobe,
   input wire [1:0] rsp_status,
   input wire pready
);

   // a request is answered only while busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe outside busy");

   // a strobe ends the request
   a_strobe_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("busy after strobe");

   // accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept without busy");

   // a result always carries a defined status
   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_status)) else $error("status unknown");

   // configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready) else $error("pready low");

endmodule

bind disk_request_scheduler drs_checker u_drs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .pready(pready)
);
`default_nettype wire
